// ===== src/kif_pkg.sv =====
// shared constants and types for the 3x3 image filter
package kif_pkg;

    localparam int LINE_WIDTH   = 64;
    localparam int FRAME_HEIGHT = 64;

    localparam int COL_W     = $clog2(LINE_WIDTH);
    localparam int ROW_W     = $clog2(FRAME_HEIGHT);
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 8;
    localparam int KROW_W    = 3 * COEF_W;
    localparam int POS_W     = 6;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int SUM_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 2'd2;

    localparam logic [KROW_W-1:0] KROW_TOP_RESET    = 24'd0;
    localparam logic [KROW_W-1:0] KROW_MID_RESET    = 24'd256;
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RESET = 24'd0;

    // [kernel row][kernel column][pixel bits]
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;
    typedef logic [2:0][KROW_W-1:0] t_kernel;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_meta;

    typedef struct packed {
        logic    valid;
        t_meta   meta;
        t_window pix;
    } t_tap;

endpackage

// ===== src/kif_line_buffer.sv =====
// position counters, two line stores and the 3x3 window
module kif_line_buffer import kif_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    output t_tap             o_tap
);

    logic [PIX_W-1:0] r_line_above     [LINE_WIDTH];
    logic [PIX_W-1:0] r_line_two_above [LINE_WIDTH];

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;

    logic             r1_valid;
    logic [PIX_W-1:0] r1_px;
    logic [PIX_W-1:0] r1_top;
    logic [PIX_W-1:0] r1_mid;
    logic [ROW_W-1:0] r1_row;
    logic [COL_W-1:0] r1_col;

    logic [PIX_W-1:0] r_win [6];

    logic [ROW_W-1:0] row_m2;
    logic [COL_W-1:0] col_m2;

    always_comb begin
        cur_row = i_frame_start ? '0 : r_row;
        cur_col = i_frame_start ? '0 : r_col;
        n_row   = cur_row;
        n_col   = cur_col + COL_W'(1);
        if (cur_col == COL_LAST) begin
            n_col = '0;
            n_row = (cur_row == ROW_LAST) ? '0 : cur_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r1_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_en) begin
                r1_valid <= i_accept;
                if (r1_valid) begin
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= r1_top;
                    r_win[4] <= r1_mid;
                    r_win[5] <= r1_px;
                end
            end
        end
    end

    // line stores: read at accept into the stage-1 registers, written back from the stage-1 item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px  <= i_pixel;
            r1_row <= cur_row;
            r1_col <= cur_col;
            r1_top <= r_line_two_above[cur_col];
            r1_mid <= r_line_above[cur_col];
            if (r1_valid) begin
                r_line_two_above[r1_col] <= r1_mid;
                r_line_above[r1_col]     <= r1_px;
            end
        end
    end

    assign row_m2 = r1_row - ROW_W'(2);
    assign col_m2 = r1_col - COL_W'(2);

    always_comb begin
        o_tap.valid    = r1_valid && (r1_row >= ROW_W'(2)) && (r1_col >= COL_W'(2));
        o_tap.meta.row = POS_W'(row_m2);
        o_tap.meta.col = POS_W'(col_m2);
        o_tap.meta.last = (r1_row == ROW_LAST) && (r1_col == COL_LAST);
        for (int a = 0; a < 3; a++) begin
            o_tap.pix[a][0] = r_win[a];
            o_tap.pix[a][1] = r_win[3 + a];
        end
        o_tap.pix[0][2] = r1_top;
        o_tap.pix[1][2] = r1_mid;
        o_tap.pix[2][2] = r1_px;
    end

`ifndef SYNTH
    a_frame_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_frame_start |=> r_col == COL_W'(1) && r_row == '0)
        else $error("frame start did not restart the position counters");

    a_col_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_frame_start && r_col == COL_LAST |=> r_col == '0)
        else $error("column counter did not wrap at end of line");

    a_window_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r1_valid |=> r_win[5] == $past(r1_px) && r_win[0] == $past(r_win[3]))
        else $error("window did not shift in the stage-1 column");
`endif

endmodule

// ===== src/kif_mac.sv =====
// nine coefficient products and the registered adder tree
module kif_mac import kif_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_tap                    i_tap,
    input  t_kernel                 i_kernel,
    output logic                    o_valid,
    output t_meta                   o_meta,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [COEF_W-1:0] n_coef [3][3];
    logic signed [PIX_W:0]    n_px   [3][3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [SUM_W-1:0]  n_rsum [3];
    logic signed [SUM_W-1:0]  r_rsum [3];

    logic  r2_valid, r3_valid;
    t_meta r2_meta, r3_meta;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                n_coef[a][b] = $signed(i_kernel[a][b*COEF_W +: COEF_W]);
                n_px[a][b]   = $signed({1'b0, i_tap.pix[a][b]});
                n_prod[a][b] = n_coef[a][b] * n_px[a][b];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_rsum[a] = SUM_W'(r_prod[a][0]) + SUM_W'(r_prod[a][1]) + SUM_W'(r_prod[a][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= i_tap.valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_meta <= i_tap.meta;
            r3_meta <= r2_meta;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_prod[a][b] <= n_prod[a][b];
                end
                r_rsum[a] <= n_rsum[a];
            end
        end
    end

    assign o_valid = r3_valid;
    assign o_meta  = r3_meta;
    assign o_sum   = r_rsum[0] + r_rsum[1] + r_rsum[2];

endmodule

// ===== src/kernel_3x3_image_filter.sv =====
// 3x3 correlation filter on a raster pixel stream
// one pixel per cycle sustained; all stages advance together unless a result is held
// from accept to a valid result, a pixel passes these registers in order:
// line store read at accept, products, row sums and final sum, each in its own register
// reset (synchronous, active low) clears counters, window and valid flags, loads identity kernel
// line stores are not cleared; only entries already written in the current frame are used
module kernel_3x3_image_filter import kif_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [PIX_W-1:0]        i_pixel,
    input  logic                    i_frame_start,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_filtered,
    output logic [POS_W-1:0]        o_out_row,
    output logic [POS_W-1:0]        o_out_col,
    output logic                    o_frame_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [KROW_W-1:0]       i_cfg_data
);

    t_kernel r_kernel;
    logic    en;
    logic    accept;
    t_tap    tap;
    logic    mac_valid;
    t_meta   mac_meta;
    logic signed [SUM_W-1:0] mac_sum;

    logic r_out_valid;

    // pipeline moves whenever the output register is free or being drained
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0] <= KROW_TOP_RESET;
            r_kernel[1] <= KROW_MID_RESET;
            r_kernel[2] <= KROW_BOTTOM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL_TOP:    r_kernel[0] <= i_cfg_data;
                REG_KERNEL_MID:    r_kernel[1] <= i_cfg_data;
                REG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kif_line_buffer u_line_buffer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_tap         (tap)
    );

    kif_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tap    (tap),
        .i_kernel (r_kernel),
        .o_valid  (mac_valid),
        .o_meta   (mac_meta),
        .o_sum    (mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_filtered   <= mac_sum;
            o_out_row    <= mac_meta.row;
            o_out_col    <= mac_meta.col;
            o_frame_last <= mac_meta.last;
        end
    end

    assign o_valid = r_out_valid;

endmodule
